>>> rtl/core/sfp_pkg.sv
`default_nettype none

package sfp_pkg;

    localparam int unsigned FrameLen  = 32;
    localparam int unsigned PosW      = $clog2(FrameLen);
    localparam int unsigned DataWords = 12;
    localparam int unsigned IdxW      = 4;

    localparam logic [7:0]      StartA    = 8'h42;
    localparam logic [7:0]      StartB    = 8'h4D;
    localparam logic [PosW-1:0] PosChkHi  = PosW'(30);
    localparam logic [PosW-1:0] PosChkLo  = PosW'(31);
    localparam logic [PosW-1:0] DataFirst = PosW'(4);
    localparam logic [IdxW-1:0] LastWord  = IdxW'(DataWords - 1);

    localparam logic STAT_GOOD = 1'b0;
    localparam logic STAT_BAD  = 1'b1;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_RD_HI,
        ST_RD_LO,
        ST_PUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/sensor_frame_parser_top.sv
// Particulate sensor 32-byte frame parser.
//
// Input channel: one received serial byte per beat on i_rx_byte
// (i_in_valid / o_in_ready). The parser hunts for 0x42 then 0x4D, stores
// the 32-byte frame in a 32 x 8 synchronous RAM and keeps a running 16-bit
// sum of bytes 0 to 29 as they arrive.
// Output channel: one data word per beat (o_out_valid / i_out_ready) with
// o_status, o_word_index, o_word_value and o_last.
// Sequencing: a bad checksum gives its single error beat from the check
// state, loaded once the output register is free. A good frame passes
// the check state, then each of the twelve words takes two reads of the
// single RAM read port, hi byte then lo byte, and a put state that loads
// the output register.
// Input: while collecting, any byte that does not end a frame is taken as soon as it is valid.
// o_in_ready is low from the last frame byte until the final result is in
// the output register; that final beat may then wait while new bytes flow.
// A stall on the output holds the result register and pauses the word
// sequencer; nothing is dropped.
// Reset: the byte position returns to hunting and all valids clear; the
// frame RAM keeps its contents and is only read after being written.

`default_nettype none

module sensor_frame_parser_top
    import sfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_status,
    output logic [IdxW-1:0]  o_word_index,
    output logic [15:0]      o_word_value,
    output logic             o_last
);

    // frame RAM, one write and one registered read port
    logic [7:0]      r_mem [FrameLen];
    logic [7:0]      r_rd_data;
    logic            rd_en;
    logic [PosW-1:0] rd_addr;
    logic            wr_en;

    t_state          r_state, n_state;
    logic [PosW-1:0] r_pos;
    logic [15:0]     r_sum;
    logic [7:0]      r_chk_hi;
    logic            r_bad;
    logic [IdxW-1:0] r_word;
    logic [7:0]      r_hi;

    logic            in_acc;
    logic            slot_free;
    logic            byte_ok;
    logic            ld_out;
    logic            n_status;
    logic [IdxW-1:0] n_word_index;
    logic [15:0]     n_word_value;
    logic            n_last;
    logic [PosW-1:0] word_addr;

    assign o_in_ready = (r_state == ST_COLLECT);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_free  = !o_out_valid || i_out_ready;

    // drop a wrong first byte, and a wrong second byte without a recheck
    always_comb begin
        byte_ok = 1'b1;
        if (r_pos == '0 && i_rx_byte != StartA) begin
            byte_ok = 1'b0;
        end else if (r_pos == PosW'(1) && i_rx_byte != StartB) begin
            byte_ok = 1'b0;
        end
    end

    assign wr_en     = in_acc && byte_ok;
    assign word_addr = {r_word, 1'b0} + DataFirst;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer: check the sum, then read hi and lo byte of each word
    always_comb begin
        n_state      = r_state;
        rd_en        = 1'b0;
        rd_addr      = word_addr;
        ld_out       = 1'b0;
        n_status     = STAT_GOOD;
        n_word_index = r_word;
        n_word_value = {r_hi, r_rd_data};
        n_last       = (r_word == LastWord);
        case (r_state)
            ST_COLLECT: begin
                if (wr_en && r_pos == PosChkLo) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_bad) begin
                    n_status     = STAT_BAD;
                    n_word_index = '0;
                    n_word_value = '0;
                    n_last       = 1'b1;
                    if (slot_free) begin
                        ld_out  = 1'b1;
                        n_state = ST_COLLECT;
                    end
                end else begin
                    n_state = ST_RD_HI;
                end
            end
            ST_RD_HI: begin
                rd_en   = 1'b1;
                n_state = ST_RD_LO;
            end
            ST_RD_LO: begin
                rd_en   = 1'b1;
                rd_addr = word_addr | PosW'(1);
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (slot_free) begin
                    ld_out  = 1'b1;
                    n_state = (r_word == LastWord) ? ST_COLLECT : ST_RD_HI;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    // position, running sum and checksum capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_acc) begin
            r_pos <= byte_ok ? r_pos + PosW'(1) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            if (r_pos == '0) begin
                r_sum <= {8'h00, i_rx_byte};
            end else if (r_pos < PosChkHi) begin
                r_sum <= r_sum + {8'h00, i_rx_byte};
            end
            if (r_pos == PosChkHi) begin
                r_chk_hi <= i_rx_byte;
            end
            if (r_pos == PosChkLo) begin
                r_bad <= (r_sum != {r_chk_hi, i_rx_byte});
            end
        end
    end

    // word counter and hi byte hold
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_word <= '0;
        end else if (r_state == ST_PUT && slot_free) begin
            r_word <= r_word + IdxW'(1);
        end
        if (r_state == ST_RD_LO) begin
            r_hi <= r_rd_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (ld_out) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            o_status     <= n_status;
            o_word_index <= n_word_index;
            o_word_value <= n_word_value;
            o_last       <= n_last;
        end
    end

    // an error beat is always alone and final
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_last && o_word_index == '0)
        else $error("error beat not final or has nonzero index");

    // a good frame ends on word eleven
    a_good_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_status && o_last |-> o_word_index == LastWord)
        else $error("good frame ended on wrong word");

    // position is back to hunting while results are produced
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_COLLECT |-> r_pos == '0)
        else $error("byte position not cleared during emission");

    // the final byte of a frame always starts the check
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_pos == PosChkLo |=> r_state == ST_CHECK)
        else $error("frame end did not start checksum");

endmodule

`default_nettype wire
